// ----- rtl/cdc_pkg.sv -----
// ----------------------------------------------------------------------------
// cdc_pkg: shared types and constants of the charge division calibration block
// Transaction structs, command and status codes, configuration register
// indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdc_pkg;

    // fixed point: positions Q1.16, table words and intermediates Q15.16
    localparam int POS_FRAC_BITS = 16;
    localparam int POS_W         = POS_FRAC_BITS + 1;
    localparam int Q_W           = 32;
    localparam int CFG_DATA_W    = 8;

    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << POS_FRAC_BITS;

    // command codes
    localparam logic [1:0] CMD_LOAD_END  = 2'd0;
    localparam logic [1:0] CMD_LOAD_COEF = 2'd1;
    localparam logic [1:0] CMD_LOOKUP    = 2'd2;
    localparam logic [1:0] CMD_CORRECT   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_GROUP_ERR  = 3'd1;
    localparam logic [2:0] ST_OUTSIDE    = 3'd2;
    localparam logic [2:0] ST_CLAMP_LOW  = 3'd3;
    localparam logic [2:0] ST_CLAMP_HIGH = 3'd4;

    // configuration register indexes
    localparam logic [0:0] CFG_GROUPS_IN_USE   = 1'd0;
    localparam logic [0:0] CFG_UNITS_PER_GROUP = 1'd1;

    // horner coefficient slots: a + p*(b + p*(c + p*d))
    localparam logic [1:0] COEF_C = 2'd2;
    localparam logic [1:0] COEF_D = 2'd3;

    typedef logic [0:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef struct packed {
        logic [1:0]           command;
        logic [4:0]           group;
        logic [3:0]           unit;
        logic [1:0]           slot;
        logic signed [Q_W-1:0] table_value;
        logic [POS_W-1:0]     position;
    } item_t;

    typedef struct packed {
        logic [3:0]       unit_index;
        logic [2:0]       status;
        logic [POS_W-1:0] corrected_position;
        logic [31:0]      clamp_low_total;
        logic [31:0]      clamp_high_total;
        logic [31:0]      group_error_total;
        logic [31:0]      outside_total;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/charge_division_calibration.sv -----
// ----------------------------------------------------------------------------
// charge_division_calibration: detector position calibration engine
// Holds per-group, per-unit position intervals and cubic correction
// polynomials; loads tables, looks up units and corrects positions.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. Each transaction gives exactly one result, shown on result
//   for one cycle with done high; the receiver cannot stall it.
//   Configuration: cfg_valid/cfg_ready write channel (cfg_ready is always
//   high); index 0 sets groups_in_use, index 1 sets units_per_group. Write
//   only while no transaction is in flight.
//   Sequencing: loads and range errors finish straight from idle; a unit
//   lookup scans the units of its group in order, the interval memories
//   delivering one unit per cycle; a position correction makes three
//   multiply-add passes through the shared unit.
//   busy stays high until the result is shown; done and the next start may
//   coincide. One transaction at a time.
//   Reset clears counters and configuration registers. Table memories are
//   not cleared: entries read before being written return arbitrary data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module charge_division_calibration #(
    parameter int MAX_GROUPS = 32,
    parameter int MAX_UNITS  = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire cdc_pkg::item_t      item,
    output logic                     done,
    output cdc_pkg::result_t         result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire cdc_pkg::cfg_index_t cfg_index,
    input  wire cdc_pkg::cfg_data_t  cfg_data
);
    import cdc_pkg::*;

    localparam int TABLE_UNITS = MAX_GROUPS * MAX_UNITS;
    localparam int UAW         = (TABLE_UNITS > 1) ? $clog2(TABLE_UNITS) : 1;
    localparam int CAW         = $clog2(TABLE_UNITS * 4);
    localparam int UCW         = $clog2(MAX_UNITS + 1);

    localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(ONE_POS);

    // sequencer states
    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE    = 3'd0;
    localparam logic [STATE_W-1:0] S_SCAN    = 3'd1;
    localparam logic [STATE_W-1:0] S_CF_LOAD = 3'd2;
    localparam logic [STATE_W-1:0] S_CF_MUL  = 3'd3;
    localparam logic [STATE_W-1:0] S_CF_ADD  = 3'd4;
    localparam logic [STATE_W-1:0] S_CF_END  = 3'd5;

    logic [STATE_W-1:0]    state_reg, state_next;
    item_t                 item_reg, item_next;
    logic [UCW-1:0]        u_reg, u_next;
    logic [UCW-1:0]        n_reg, n_next;
    logic [1:0]            k_reg, k_next;
    logic signed [Q_W-1:0] t_reg, t_next;
    logic                  done_reg, done_next;
    logic [3:0]            res_unit_reg, res_unit_next;
    logic [2:0]            res_status_reg, res_status_next;
    logic [POS_W-1:0]      res_pos_reg, res_pos_next;
    logic [31:0]           clamp_low_reg, clamp_low_next;
    logic [31:0]           clamp_high_reg, clamp_high_next;
    logic [31:0]           group_err_reg, group_err_next;
    logic [31:0]           outside_reg, outside_next;
    logic [5:0]            groups_in_use_reg;
    logic [4:0]            units_per_group_reg;

    logic                  accept;
    logic                  in_table;
    logic                  lookup_err;
    logic                  correct_err;
    logic [UCW-1:0]        scan_len;
    logic [31:0]           idx_full;
    logic [POS_W-1:0]      end_value;

    logic [4:0]            sel_group;
    logic [3:0]            sel_unit;
    logic [UCW-1:0]        scan_u;
    logic [1:0]            coef_slot;
    logic [31:0]           scan_addr_full;
    logic [31:0]           coef_raddr_full;
    logic [31:0]           coef_waddr_full;

    logic                  ivl_we0, ivl_we1, ivl_re;
    logic                  coef_we, coef_re;
    logic                  mul_en;
    logic [POS_W-1:0]      end0_rdata, end1_rdata;
    logic [POS_W-1:0]      ivl_lo, ivl_hi;
    logic                  ivl_hit;
    logic signed [Q_W-1:0] coef_rdata;
    logic signed [Q_W-1:0] mac_sum;
    logic signed [Q_W+1:0] diff;

    // request decode on the incoming transaction
    assign accept      = start && (state_reg == S_IDLE);
    assign in_table    = (32'(item.group) < MAX_GROUPS) && (32'(item.unit) < MAX_UNITS);
    assign lookup_err  = ({1'b0, item.group} >= groups_in_use_reg)
                         || (32'(item.group) >= MAX_GROUPS);
    assign correct_err = !in_table || ({1'b0, item.group} >= groups_in_use_reg)
                         || ({1'b0, item.unit} >= units_per_group_reg);
    assign scan_len    = (32'(units_per_group_reg) < MAX_UNITS)
                         ? UCW'(units_per_group_reg) : UCW'(MAX_UNITS);
    assign idx_full    = 32'(item.group) * 32'(MAX_UNITS) + 32'(item.unit);

    // interval end saturated to [0, 1.0]
    always_comb
    begin
        if (item.table_value[Q_W-1])
            end_value = '0;
        else if (item.table_value > ONE_Q)
            end_value = ONE_POS;
        else
            end_value = item.table_value[POS_W-1:0];
    end

    // table read addresses
    assign sel_group       = (state_reg == S_IDLE) ? item.group : item_reg.group;
    assign sel_unit        = (state_reg == S_IDLE) ? item.unit : item_reg.unit;
    assign scan_u          = (state_reg == S_IDLE) ? '0 : UCW'(u_reg + 1'b1);
    assign scan_addr_full  = 32'(sel_group) * 32'(MAX_UNITS) + 32'(scan_u);
    assign coef_raddr_full = (32'(sel_group) * 32'(MAX_UNITS) + 32'(sel_unit)) * 32'd4
                             + 32'(coef_slot);
    assign coef_waddr_full = idx_full * 32'd4 + 32'(item.slot);

    always_comb
    begin
        case (state_reg)
            S_IDLE:    coef_slot = COEF_D;
            S_CF_LOAD: coef_slot = COEF_C;
            default:   coef_slot = 2'(k_reg - 2'd1);
        endcase
    end

    // interval compare, ends in either order
    assign ivl_lo  = (end0_rdata < end1_rdata) ? end0_rdata : end1_rdata;
    assign ivl_hi  = (end0_rdata < end1_rdata) ? end1_rdata : end0_rdata;
    assign ivl_hit = (item_reg.position >= ivl_lo) && (item_reg.position <= ivl_hi);

    // final subtract
    assign diff = $signed({{(Q_W+2-POS_W){1'b0}}, item_reg.position})
                  - $signed({{2{t_reg[Q_W-1]}}, t_reg});

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        u_next          = u_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        t_next          = t_reg;
        done_next       = 1'b0;
        res_unit_next   = res_unit_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        clamp_low_next  = clamp_low_reg;
        clamp_high_next = clamp_high_reg;
        group_err_next  = group_err_reg;
        outside_next    = outside_reg;
        ivl_we0         = 1'b0;
        ivl_we1         = 1'b0;
        ivl_re          = 1'b0;
        coef_we         = 1'b0;
        coef_re         = 1'b0;
        mul_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next       = item;
                    res_unit_next   = '0;
                    res_status_next = ST_OK;
                    res_pos_next    = '0;
                    case (item.command)
                        CMD_LOAD_END:
                        begin
                            ivl_we0   = in_table && (item.slot == 2'd0);
                            ivl_we1   = in_table && (item.slot == 2'd1);
                            done_next = 1'b1;
                        end
                        CMD_LOAD_COEF:
                        begin
                            coef_we   = in_table;
                            done_next = 1'b1;
                        end
                        CMD_LOOKUP:
                        begin
                            if (lookup_err)
                            begin
                                res_status_next = ST_GROUP_ERR;
                                group_err_next  = group_err_reg + 32'd1;
                                done_next       = 1'b1;
                            end
                            else if (scan_len == '0)
                            begin
                                res_status_next = ST_OUTSIDE;
                                outside_next    = outside_reg + 32'd1;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                ivl_re     = 1'b1;
                                u_next     = '0;
                                n_next     = scan_len;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_CORRECT:
                        begin
                            if (correct_err)
                            begin
                                res_status_next = ST_GROUP_ERR;
                                group_err_next  = group_err_reg + 32'd1;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                coef_re    = 1'b1;
                                state_next = S_CF_LOAD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // one unit per cycle; the next unit's read is issued alongside
            S_SCAN:
            begin
                if (ivl_hit)
                begin
                    res_unit_next = 4'(u_reg);
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (UCW'(u_reg + 1'b1) == n_reg)
                begin
                    res_status_next = ST_OUTSIDE;
                    outside_next    = outside_reg + 32'd1;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    u_next = UCW'(u_reg + 1'b1);
                    ivl_re = 1'b1;
                end
            end

            // t starts as the cubic coefficient
            S_CF_LOAD:
            begin
                t_next     = coef_rdata;
                k_next     = COEF_C;
                coef_re    = 1'b1;
                state_next = S_CF_MUL;
            end

            S_CF_MUL:
            begin
                mul_en     = 1'b1;
                state_next = S_CF_ADD;
            end

            S_CF_ADD:
            begin
                t_next = mac_sum;
                if (k_reg == 2'd0)
                begin
                    state_next = S_CF_END;
                end
                else
                begin
                    k_next     = 2'(k_reg - 2'd1);
                    coef_re    = 1'b1;
                    state_next = S_CF_MUL;
                end
            end

            // position minus delta, clamped to [0, 1.0]
            S_CF_END:
            begin
                if (diff < 0)
                begin
                    res_pos_next    = '0;
                    res_status_next = ST_CLAMP_LOW;
                    clamp_low_next  = clamp_low_reg + 32'd1;
                end
                else if (diff > $signed((Q_W+2)'(ONE_POS)))
                begin
                    res_pos_next    = ONE_POS;
                    res_status_next = ST_CLAMP_HIGH;
                    clamp_high_next = clamp_high_reg + 32'd1;
                end
                else
                begin
                    res_pos_next = diff[POS_W-1:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            u_reg          <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            res_unit_reg   <= '0;
            res_status_reg <= ST_OK;
            res_pos_reg    <= '0;
            clamp_low_reg  <= '0;
            clamp_high_reg <= '0;
            group_err_reg  <= '0;
            outside_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            u_reg          <= u_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            res_unit_reg   <= res_unit_next;
            res_status_reg <= res_status_next;
            res_pos_reg    <= res_pos_next;
            clamp_low_reg  <= clamp_low_next;
            clamp_high_reg <= clamp_high_next;
            group_err_reg  <= group_err_next;
            outside_reg    <= outside_next;
        end
    end

    // transaction payload and polynomial accumulator
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        t_reg    <= t_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_in_use_reg   <= '0;
            units_per_group_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GROUPS_IN_USE:   groups_in_use_reg   <= cfg_data[5:0];
                CFG_UNITS_PER_GROUP: units_per_group_reg <= cfg_data[4:0];
                default:             ;
            endcase
        end
    end

    // table memories
    cdc_ram #(
        .WIDTH (POS_W),
        .DEPTH (TABLE_UNITS)
    ) u_end0_ram (
        .clk   (clk),
        .we    (ivl_we0),
        .waddr (idx_full[UAW-1:0]),
        .wdata (end_value),
        .re    (ivl_re),
        .raddr (scan_addr_full[UAW-1:0]),
        .rdata (end0_rdata)
    );

    cdc_ram #(
        .WIDTH (POS_W),
        .DEPTH (TABLE_UNITS)
    ) u_end1_ram (
        .clk   (clk),
        .we    (ivl_we1),
        .waddr (idx_full[UAW-1:0]),
        .wdata (end_value),
        .re    (ivl_re),
        .raddr (scan_addr_full[UAW-1:0]),
        .rdata (end1_rdata)
    );

    cdc_ram #(
        .WIDTH (Q_W),
        .DEPTH (TABLE_UNITS * 4)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr_full[CAW-1:0]),
        .wdata (item.table_value),
        .re    (coef_re),
        .raddr (coef_raddr_full[CAW-1:0]),
        .rdata (coef_rdata)
    );

    // shared multiply-accumulate unit
    cdc_mac u_mac (
        .clk          (clk),
        .mul_en       (mul_en),
        .position     (item_reg.position),
        .multiplicand (t_reg),
        .addend       (coef_rdata),
        .sum          (mac_sum)
    );

    // outputs
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign cfg_ready = 1'b1;

    assign result.unit_index         = res_unit_reg;
    assign result.status             = res_status_reg;
    assign result.corrected_position = res_pos_reg;
    assign result.clamp_low_total    = clamp_low_reg;
    assign result.clamp_high_total   = clamp_high_reg;
    assign result.group_error_total  = group_err_reg;
    assign result.outside_total      = outside_reg;

    // checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted transaction neither started nor finished");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while sequencer busy");

    // a second strobe right away needs a new transaction accepted while the first is shown
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accept) |=> !done)
        else $error("result strobe without a transaction");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (u_reg < n_reg))
        else $error("lookup scan ran past the unit count");

    a_clamp_low: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_CLAMP_LOW)) |-> (result.corrected_position == '0))
        else $error("low clamp with nonzero position");

    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_GROUP_ERR))
        |-> (result.group_error_total == 32'($past(group_err_reg) + 32'd1)))
        else $error("group error not counted");

endmodule

`default_nettype wire

// ----- rtl/cdc_ram.sv -----
// ----------------------------------------------------------------------------
// cdc_ram: generic single write port, single read port RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // storage write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cdc_mac.sv -----
// ----------------------------------------------------------------------------
// cdc_mac: shared multiply-accumulate unit for the correction polynomial
// Registers position * operand, then floors the product to Q15.16, saturates
// it, adds the coefficient and saturates the sum to the signed 32-bit range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdc_mac (
    input  wire logic                          clk,
    input  wire logic                          mul_en,
    input  wire logic [cdc_pkg::POS_W-1:0]     position,
    input  wire logic signed [cdc_pkg::Q_W-1:0] multiplicand,
    input  wire logic signed [cdc_pkg::Q_W-1:0] addend,
    output logic signed [cdc_pkg::Q_W-1:0]     sum
);
    import cdc_pkg::*;

    localparam int PROD_W = POS_W + 1 + Q_W;

    logic signed [POS_W:0]    mul_a;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] scaled;
    logic signed [Q_W-1:0]    scaled_sat;
    logic signed [PROD_W-1:0] addend_ext;
    logic signed [PROD_W-1:0] scaled_ext;
    logic signed [PROD_W-1:0] sum_wide;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] max_v;
        logic signed [PROD_W-1:0] min_v;
        max_v = {{(PROD_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
        min_v = {{(PROD_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
        if (v > max_v)
            sat_q = max_v[Q_W-1:0];
        else if (v < min_v)
            sat_q = min_v[Q_W-1:0];
        else
            sat_q = v[Q_W-1:0];
    endfunction

    // product stage
    assign mul_a     = {1'b0, position};
    assign prod_next = mul_a * multiplicand;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // floor scaling, saturation and accumulate
    assign scaled     = prod_reg >>> POS_FRAC_BITS;
    assign scaled_sat = sat_q(scaled);
    assign addend_ext = {{(PROD_W-Q_W){addend[Q_W-1]}}, addend};
    assign scaled_ext = {{(PROD_W-Q_W){scaled_sat[Q_W-1]}}, scaled_sat};
    assign sum_wide   = addend_ext + scaled_ext;
    assign sum        = sat_q(sum_wide);

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for charge_division_calibration
// Drives load, lookup and correction transactions through the start/busy
// command port and compares every result against an in-bench predictor of
// the interval and polynomial tables. A short directed table comes first,
// then random phases, each under its own register setting. The random part
// loads every table word before it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import cdc_pkg::*;

    localparam int GROUPS       = 32;
    localparam int UNITS        = 16;
    localparam int UNIT_SPAN    = 4096;     // interval width used when filling a group
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 130;
    localparam int QUIET_PHASE  = 4;        // phase run with no input gaps
    localparam int CFG_ROW      = 10;       // directed row where registers get set
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTS   = 40;
    localparam longint TIMEOUT_NS = 5_000_000;

    typedef struct {
        item_t          stim;
        bit             typed;
        logic [2:0]     status;
        logic [POS_W-1:0] corrected;
    } directed_row_t;

    // DUT signals; the inputs are driven to known values from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    item_t      cmd_item = '0;
    logic       done;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_GROUPS_IN_USE;
    cfg_data_t  cfg_data = '0;

    // predictor state
    logic [POS_W-1:0]   end_first [GROUPS*UNITS];
    logic [POS_W-1:0]   end_second[GROUPS*UNITS];
    logic signed [31:0] coef_words[GROUPS*UNITS*4];
    bit                 end_set   [GROUPS*UNITS][2];
    bit                 coef_set  [GROUPS*UNITS*4];
    logic [31:0]        low_clamps;
    logic [31:0]        high_clamps;
    logic [31:0]        group_errors;
    logic [31:0]        misses;
    logic [5:0]         groups_cfg;
    logic [4:0]         units_cfg;

    result_t       calib_results_q[$];
    directed_row_t directed_rows[$];
    result_t       head;
    bit            gaps_on = 1'b1;
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            settings_used = 0;
    int            sent_by_cmd[4];
    int            seen_status[8];

    always #4 clk = ~clk;

    charge_division_calibration u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (cmd_item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // signed 32-bit saturation
    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q15.16 product, floor after the shift, then saturation
    function automatic logic signed [31:0] q16_mul(input longint p, input logic signed [31:0] c);
        longint prod;
        prod = p * longint'(c);
        return clip32(prod >>> POS_FRAC_BITS);
    endfunction

    // predicted outcome of one accepted transaction; updates tables and counts
    function automatic result_t compute_calibration(input item_t it);
        result_t            r;
        int                 idx;
        int                 n;
        int                 k;
        bit                 hit;
        longint             v;
        longint             p;
        longint             e0;
        longint             e1;
        longint             lo;
        longint             hi;
        longint             corr;
        logic signed [31:0] t;
        logic signed [31:0] delta;
        r = '0;
        idx = it.group * UNITS + it.unit;
        p = longint'(it.position);
        case (it.command)
            CMD_LOAD_END:
            begin
                if (it.slot < 2)
                begin
                    v = longint'(it.table_value);
                    if (v < 0)
                        v = 0;
                    if (v > longint'(ONE_POS))
                        v = longint'(ONE_POS);
                    if (it.slot == 0)
                        end_first[idx] = v[POS_W-1:0];
                    else
                        end_second[idx] = v[POS_W-1:0];
                    end_set[idx][it.slot[0]] = 1'b1;
                end
            end
            CMD_LOAD_COEF:
            begin
                coef_words[idx*4 + it.slot] = it.table_value;
                coef_set[idx*4 + it.slot] = 1'b1;
            end
            CMD_LOOKUP:
            begin
                if (it.group >= groups_cfg)
                begin
                    r.status = ST_GROUP_ERR;
                    group_errors++;
                end
                else
                begin
                    n = (units_cfg < UNITS) ? units_cfg : UNITS;
                    hit = 1'b0;
                    for (int u = 0; u < n && !hit; u++)
                    begin
                        k = it.group * UNITS + u;
                        e0 = longint'(end_first[k]);
                        e1 = longint'(end_second[k]);
                        lo = (e0 < e1) ? e0 : e1;
                        hi = (e0 < e1) ? e1 : e0;
                        if (p >= lo && p <= hi)
                        begin
                            hit = 1'b1;
                            r.unit_index = u[3:0];
                        end
                    end
                    if (!hit)
                    begin
                        r.status = ST_OUTSIDE;
                        misses++;
                    end
                end
            end
            default:
            begin
                if (it.group >= groups_cfg || it.unit >= units_cfg)
                begin
                    r.status = ST_GROUP_ERR;
                    group_errors++;
                end
                else
                begin
                    // horner: a + p*(b + p*(c + p*d))
                    t = clip32(longint'(coef_words[idx*4 + 2]) +
                               longint'(q16_mul(p, coef_words[idx*4 + 3])));
                    t = clip32(longint'(coef_words[idx*4 + 1]) + longint'(q16_mul(p, t)));
                    delta = clip32(longint'(coef_words[idx*4]) + longint'(q16_mul(p, t)));
                    corr = longint'(clip32(p - longint'(delta)));
                    if (corr < 0)
                    begin
                        corr = 0;
                        low_clamps++;
                        r.status = ST_CLAMP_LOW;
                    end
                    if (corr > longint'(ONE_POS))
                    begin
                        corr = longint'(ONE_POS);
                        high_clamps++;
                        r.status = ST_CLAMP_HIGH;
                    end
                    r.corrected_position = corr[POS_W-1:0];
                end
            end
        endcase
        r.clamp_low_total   = low_clamps;
        r.clamp_high_total  = high_clamps;
        r.group_error_total = group_errors;
        r.outside_total     = misses;
        return r;
    endfunction

    // coefficient word: mostly small, sometimes a few units, sometimes anything
    function automatic logic signed [31:0] pick_coefficient();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 32'(int'($urandom_range(0, 16384)) - 8192);
        if (r < 9)
            return 32'(int'($urandom_range(0, 262144)) - 131072);
        return $urandom;
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input int g, input int u,
                                    input int s, input logic signed [31:0] val,
                                    input int pos, input bit typed,
                                    input logic [2:0] st, input int corr);
        directed_row_t row;
        row.stim.command     = cmd;
        row.stim.group       = 5'(g);
        row.stim.unit        = 4'(u);
        row.stim.slot        = 2'(s);
        row.stim.table_value = val;
        row.stim.position    = POS_W'(pos);
        row.typed            = typed;
        row.status           = st;
        row.corrected        = POS_W'(corr);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // one transaction: optional gap, then hold start until busy is low at an edge
    task automatic send_item(input item_t it);
        bit taken;
        while (gaps_on && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd_item <= it;
        forever
        begin
            @(negedge clk);
            taken = (busy === 1'b0);
            @(posedge clk);
            if (taken)
                break;
        end
        calib_results_q.insert(calib_results_q.size(), compute_calibration(it));
        sent_by_cmd[it.command]++;
        items_sent++;
    endtask

    // drain outstanding work, then write both registers
    task automatic apply_settings(input int gu, input int upg);
        bit taken;
        start <= 1'b0;
        wait (calib_results_q.size() == 0);
        @(posedge clk);
        repeat (3) @(posedge clk);
        for (int i = 0; i < 2; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? CFG_GROUPS_IN_USE : CFG_UNITS_PER_GROUP;
            cfg_data  <= cfg_data_t'((i == 0) ? gu : upg);
            forever
            begin
                @(negedge clk);
                taken = (cfg_ready === 1'b1);
                @(posedge clk);
                if (taken)
                    break;
            end
        end
        cfg_valid <= 1'b0;
        groups_cfg = 6'(gu);
        units_cfg  = 5'(upg);
        settings_used++;
    endtask

    // result checker: done is held one full cycle, sampled mid-cycle
    always @(negedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            seen_status[result.status]++;
            if (calib_results_q.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                head = calib_results_q.pop_front();
                if (result.unit_index !== head.unit_index)
                    report_mismatch($sformatf("unit_index got %0d want %0d",
                                              result.unit_index, head.unit_index));
                if (result.status !== head.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result.status, head.status));
                if (result.corrected_position !== head.corrected_position)
                    report_mismatch($sformatf("corrected_position got %0d want %0d",
                                              result.corrected_position,
                                              head.corrected_position));
                if (result.clamp_low_total !== head.clamp_low_total)
                    report_mismatch($sformatf("clamp_low_total got %0d want %0d",
                                              result.clamp_low_total, head.clamp_low_total));
                if (result.clamp_high_total !== head.clamp_high_total)
                    report_mismatch($sformatf("clamp_high_total got %0d want %0d",
                                              result.clamp_high_total, head.clamp_high_total));
                if (result.group_error_total !== head.group_error_total)
                    report_mismatch($sformatf("group_error_total got %0d want %0d",
                                              result.group_error_total,
                                              head.group_error_total));
                if (result.outside_total !== head.outside_total)
                    report_mismatch($sformatf("outside_total got %0d want %0d",
                                              result.outside_total, head.outside_total));
            end
        end
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        directed_row_t      row;
        result_t            typed_res;
        item_t              it;
        item_t              prep;
        int                 phase_end;
        int                 n;
        int                 r;
        int                 lo_v;
        int                 hi_v;
        bit                 swap;
        int                 gu_list[PHASES];
        int                 upg_list[PHASES];

        low_clamps   = '0;
        high_clamps  = '0;
        group_errors = '0;
        misses       = '0;
        groups_cfg   = '0;
        units_cfg    = '0;
        gu_list  = '{4, 32, 0, 1, 32, 0, 3, -1, -1, 2};
        upg_list = '{16, 16, 0, 1, 0, 16, 5, -1, -1, 16};

        // directed table; registers at reset value (no groups, no units)
        add_row(CMD_LOOKUP,    0, 0, 0, 32'sd0, 0, 1, ST_GROUP_ERR, 0);
        add_row(CMD_CORRECT,   0, 0, 0, 32'sd0, 65536, 1, ST_GROUP_ERR, 0);
        add_row(CMD_LOAD_END, 31, 0, 0, 32'sd40000, 0, 1, ST_OK, 0);
        add_row(CMD_LOAD_END, 31, 0, 1, -32'sd7, 0, 1, ST_OK, 0);        // saturates to 0
        add_row(CMD_LOAD_END, 31, 0, 2, 32'sd12345, 0, 1, ST_OK, 0);     // bad slot, ignored
        add_row(CMD_LOAD_END, 31, 0, 3, 32'sh7FFF_FFFF, 0, 1, ST_OK, 0); // bad slot, ignored
        add_row(CMD_LOAD_COEF, 31, 0, 0, 32'sd0, 0, 1, ST_OK, 0);
        add_row(CMD_LOAD_COEF, 31, 0, 1, 32'sd0, 0, 1, ST_OK, 0);
        add_row(CMD_LOAD_COEF, 31, 0, 2, 32'sd0, 0, 1, ST_OK, 0);
        add_row(CMD_LOAD_COEF, 31, 0, 3, 32'sd0, 0, 1, ST_OK, 0);
        // from here: 32 groups, 1 unit per group
        add_row(CMD_LOOKUP,   31, 0, 0, 32'sd0, 40000, 1, ST_OK, 0);     // inclusive upper end
        add_row(CMD_LOOKUP,   31, 0, 0, 32'sd0, 40001, 1, ST_OUTSIDE, 0);
        add_row(CMD_LOOKUP,   31, 0, 0, 32'sd0, 0, 1, ST_OK, 0);
        add_row(CMD_CORRECT,  31, 0, 0, 32'sd0, 65536, 1, ST_OK, 65536); // zero polynomial
        add_row(CMD_CORRECT,  31, 1, 0, 32'sd0, 0, 1, ST_GROUP_ERR, 0);  // unit past range
        add_row(CMD_LOAD_COEF, 31, 0, 0, 32'sh8000_0000, 0, 1, ST_OK, 0);
        add_row(CMD_CORRECT,  31, 0, 0, 32'sd0, 0, 1, ST_CLAMP_HIGH, 65536);
        add_row(CMD_LOAD_COEF, 31, 0, 0, 32'sh7FFF_FFFF, 0, 1, ST_OK, 0);
        add_row(CMD_CORRECT,  31, 0, 0, 32'sd0, 131071, 1, ST_CLAMP_LOW, 0);
        add_row(CMD_LOAD_COEF, 31, 0, 0, 32'sd0, 0, 1, ST_OK, 0);
        add_row(CMD_LOAD_COEF, 31, 0, 3, 32'sh7FFF_FFFF, 0, 1, ST_OK, 0);
        add_row(CMD_CORRECT,  31, 0, 0, 32'sd0, 131071, 0, ST_OK, 0);    // product saturation
        add_row(CMD_LOAD_COEF, 31, 0, 3, 32'sh8000_0000, 0, 1, ST_OK, 0);
        add_row(CMD_CORRECT,  31, 0, 0, 32'sd0, 131071, 0, ST_OK, 0);
        add_row(CMD_LOAD_COEF, 31, 0, 1, 32'sh0001_0000, 0, 1, ST_OK, 0);
        add_row(CMD_CORRECT,  31, 0, 0, 32'sd0, 32768, 0, ST_OK, 0);

        // reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk
        for (int i = 0; i < directed_rows.size(); i++)
        begin
            if (i == CFG_ROW)
                apply_settings(GROUPS, 1);
            row = directed_rows[i];
            send_item(row.stim);
            if (row.typed)
            begin
                typed_res = calib_results_q.pop_back();
                typed_res.unit_index         = '0;
                typed_res.status             = row.status;
                typed_res.corrected_position = row.corrected;
                calib_results_q.insert(calib_results_q.size(), typed_res);
            end
        end

        // random phases
        for (int ph = 0; ph < PHASES; ph++)
        begin
            apply_settings((gu_list[ph] < 0) ? int'($urandom_range(0, 32)) : gu_list[ph],
                           (upg_list[ph] < 0) ? int'($urandom_range(0, 16)) : upg_list[ph]);
            gaps_on = (ph != QUIET_PHASE);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                it = '0;
                // mostly a few busy groups, some anywhere, some past the range
                r = $urandom_range(0, 9);
                if (r < 8)
                    it.group = 5'($urandom_range(0, 3));
                else if (r == 9 && groups_cfg < GROUPS)
                    it.group = 5'($urandom_range(groups_cfg, 31));
                else
                    it.group = 5'($urandom_range(0, 31));
                if (units_cfg != 0 && $urandom_range(0, 9) < 7)
                    it.unit = 4'($urandom_range(0, units_cfg - 1));
                else
                    it.unit = 4'($urandom_range(0, 15));
                it.slot = 2'($urandom_range(0, 3));
                it.table_value = $urandom;
                // positions: plain, ends of range, above 1.0, near interval edges
                r = $urandom_range(0, 19);
                if (r == 0)
                    it.position = POS_W'($urandom_range(0, 131071));
                else if (r == 1)
                    it.position = '0;
                else if (r == 2)
                    it.position = ONE_POS;
                else if (r < 5)
                    it.position = POS_W'(int'($urandom_range(0, 16)) * UNIT_SPAN +
                                         int'($urandom_range(0, 2)) - 1);
                else
                    it.position = POS_W'($urandom_range(0, 65536));

                r = $urandom_range(0, 19);
                if (r < 3)
                begin
                    it.command = CMD_LOAD_END;
                    if ($urandom_range(0, 9) < 6)
                        it.table_value = 32'($urandom_range(0, 65536));
                end
                else if (r < 6)
                begin
                    it.command = CMD_LOAD_COEF;
                    it.table_value = pick_coefficient();
                end
                else if (r < 13)
                    it.command = CMD_LOOKUP;
                else
                    it.command = CMD_CORRECT;

                // a lookup reads every scanned interval: load missing ones first
                if (it.command == CMD_LOOKUP && it.group < groups_cfg)
                begin
                    n = (units_cfg < UNITS) ? units_cfg : UNITS;
                    for (int u = 0; u < n; u++)
                    begin
                        swap = $urandom_range(0, 1);
                        lo_v = u * UNIT_SPAN - int'($urandom_range(0, 200));
                        hi_v = u * UNIT_SPAN + UNIT_SPAN - 1 + int'($urandom_range(0, 200));
                        for (int s = 0; s < 2; s++)
                        begin
                            if (!end_set[it.group * UNITS + u][s])
                            begin
                                prep = '0;
                                prep.command = CMD_LOAD_END;
                                prep.group = it.group;
                                prep.unit = 4'(u);
                                prep.slot = 2'(s);
                                prep.table_value = ((s == 1) ^ swap) ? 32'(hi_v) : 32'(lo_v);
                                prep.position = POS_W'($urandom_range(0, 65536));
                                send_item(prep);
                            end
                        end
                    end
                end

                // a correction reads all four words of its polynomial
                if (it.command == CMD_CORRECT && it.group < groups_cfg &&
                    it.unit < units_cfg)
                begin
                    for (int s = 0; s < 4; s++)
                    begin
                        if (!coef_set[(it.group * UNITS + it.unit) * 4 + s])
                        begin
                            prep = '0;
                            prep.command = CMD_LOAD_COEF;
                            prep.group = it.group;
                            prep.unit = it.unit;
                            prep.slot = 2'(s);
                            prep.table_value = pick_coefficient();
                            prep.position = POS_W'($urandom_range(0, 65536));
                            send_item(prep);
                        end
                    end
                end

                send_item(it);
            end
        end

        // wind down
        start <= 1'b0;
        wait (calib_results_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions: %0d interval loads, %0d coefficient loads,",
                 items_sent, sent_by_cmd[CMD_LOAD_END], sent_by_cmd[CMD_LOAD_COEF]);
        $display("  %0d lookups, %0d corrections, %0d register settings",
                 sent_by_cmd[CMD_LOOKUP], sent_by_cmd[CMD_CORRECT], settings_used);
        $display("results seen: %0d ok, %0d group errors, %0d outside,",
                 seen_status[ST_OK], seen_status[ST_GROUP_ERR], seen_status[ST_OUTSIDE]);
        $display("  %0d clamped low, %0d clamped high",
                 seen_status[ST_CLAMP_LOW], seen_status[ST_CLAMP_HIGH]);
        if (mismatch_count == 0 && calib_results_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
